### hdl/rvd_pkg.sv
// Package for the RV64I instruction decoder: opcode constants, format and
// operation codes, and the beat structs passed between pipeline stages.
// No dependencies.
package rvd_pkg;

  // Major opcodes, bits 6:0 of the instruction word
  localparam logic [6:0] OPCODE_OP     = 7'b0110011;
  localparam logic [6:0] OPCODE_OP32   = 7'b0111011;
  localparam logic [6:0] OPCODE_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPCODE_LOAD   = 7'b0000011;
  localparam logic [6:0] OPCODE_SYSTEM = 7'b1110011;
  localparam logic [6:0] OPCODE_JALR   = 7'b1100111;
  localparam logic [6:0] OPCODE_OPIMM32 = 7'b0011011;
  localparam logic [6:0] OPCODE_STORE  = 7'b0100011;
  localparam logic [6:0] OPCODE_BRANCH = 7'b1100011;
  localparam logic [6:0] OPCODE_LUI    = 7'b0110111;
  localparam logic [6:0] OPCODE_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPCODE_JAL    = 7'b1101111;

  // funct7 values used by the base ISA
  localparam logic [6:0] FUNCT7_BASE = 7'b0000000;
  localparam logic [6:0] FUNCT7_ALT  = 7'b0100000;
  // upper six immediate bits of an arithmetic right shift
  localparam logic [5:0] SHIFT_HI_ALT = 6'b010000;

  typedef enum logic [3:0] {
    CLS_OP, CLS_OP32, CLS_OPIMM, CLS_LOAD, CLS_SYSTEM, CLS_JALR,
    CLS_OPIMM32, CLS_STORE, CLS_BRANCH, CLS_LUI, CLS_AUIPC, CLS_JAL,
    CLS_NONE
  } opc_cls_e;

  typedef enum logic [2:0] {
    FMT_R = 3'd0, FMT_I = 3'd1, FMT_S = 3'd2, FMT_B = 3'd3,
    FMT_U = 3'd4, FMT_J = 3'd5
  } fmt_e;

  typedef enum logic [5:0] {
    OP_ADD, OP_SUB, OP_XOR, OP_OR, OP_AND, OP_SLL, OP_SRL, OP_SRA,
    OP_SLT, OP_SLTU, OP_SUBW, OP_ADDW, OP_SLLW, OP_SRLW, OP_SRAW,
    OP_ADDI, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI,
    OP_SLTI, OP_SLTIU, OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU,
    OP_LWU, OP_ECALL, OP_EBREAK, OP_JALR, OP_ADDIW, OP_SLLIW,
    OP_SRLIW, OP_SRAIW, OP_SB, OP_SH, OP_SW, OP_SD, OP_BEQ, OP_BNE,
    OP_BLT, OP_BGE, OP_BLTU, OP_BGEU, OP_LUI, OP_AUIPC, OP_JAL
  } op_e;

  // Beat leaving the opcode stage
  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    opc_cls_e    cls;
  } s1_t;

  // Beat leaving the operation stage
  typedef struct packed {
    logic        valid;
    logic        bad;
    fmt_e        fmt;
    op_e         op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [20:0] imm;
  } s2_t;

endpackage

### hdl/rv64i_instruction_decoder.sv
// Top level of the RV64I instruction decoder: three register stages.
// Depends on rvd_pkg, rvd_opc_stage, rvd_op_stage and rvd_out_stage.
//
//   channel   handshake            payload
//   command   start / busy         instr_word_i
//   result    done_o (one cycle)   invalid_o format_o operation_o dest_reg_o
//                                  src1_reg_o src2_reg_o immediate_o
//
// One instruction per cycle; the result strobe is registered in turn by the
// opcode stage, the operation stage and the output register.
// busy stays low: every stage advances each cycle, since results are
// never held off by the receiver.
// Reset clears the valid bits of all stages; payload registers keep data.
module rv64i_instruction_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        instr_word_i,
  output logic               done_o,
  output logic               invalid_o,
  output logic [2:0]         format_o,
  output logic [5:0]         operation_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic signed [20:0] immediate_o
);
  import rvd_pkg::*;

  s1_t         s1;
  s2_t         s2;
  logic        accept;
  logic [20:0] imm_raw;

  // The pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rvd_opc_stage u_opc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (instr_word_i),
    .s1_o     (s1)
  );

  rvd_op_stage u_op (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1),
    .s2_o   (s2)
  );

  rvd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_i        (s2),
    .done_o      (done_o),
    .invalid_o   (invalid_o),
    .format_o    (format_o),
    .operation_o (operation_o),
    .dest_reg_o  (dest_reg_o),
    .src1_reg_o  (src1_reg_o),
    .src2_reg_o  (src2_reg_o),
    .immediate_o (imm_raw)
  );

  assign immediate_o = signed'(imm_raw);

endmodule

### hdl/rvd_opc_stage.sv
// First pipeline stage: registers the instruction word and classifies its
// major opcode. Depends on rvd_pkg.
module rvd_opc_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [31:0]  word_i,
  output rvd_pkg::s1_t s1_o
);
  import rvd_pkg::*;

  opc_cls_e   cls_d;
  logic       valid_q;
  logic [31:0] word_q;
  opc_cls_e   cls_q;

  // Classify the major opcode
  always_comb begin
    case (word_i[6:0])
      OPCODE_OP:      cls_d = CLS_OP;
      OPCODE_OP32:    cls_d = CLS_OP32;
      OPCODE_OPIMM:   cls_d = CLS_OPIMM;
      OPCODE_LOAD:    cls_d = CLS_LOAD;
      OPCODE_SYSTEM:  cls_d = CLS_SYSTEM;
      OPCODE_JALR:    cls_d = CLS_JALR;
      OPCODE_OPIMM32: cls_d = CLS_OPIMM32;
      OPCODE_STORE:   cls_d = CLS_STORE;
      OPCODE_BRANCH:  cls_d = CLS_BRANCH;
      OPCODE_LUI:     cls_d = CLS_LUI;
      OPCODE_AUIPC:   cls_d = CLS_AUIPC;
      OPCODE_JAL:     cls_d = CLS_JAL;
      default:        cls_d = CLS_NONE;
    endcase
  end

  // Track the valid bit of the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  // Hold payload of an accepted beat
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      word_q <= word_i;
      cls_q  <= cls_d;
    end
  end

  assign s1_o = '{valid: valid_q, word: word_q, cls: cls_q};

endmodule

### hdl/rvd_op_stage.sv
// Second pipeline stage: checks funct fields, picks the operation and format,
// selects register fields and assembles the immediate. Depends on rvd_pkg.
module rvd_op_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rvd_pkg::s1_t s1_i,
  output rvd_pkg::s2_t s2_o
);
  import rvd_pkg::*;

  logic [31:0] w;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd_f;
  logic [4:0]  rs1_f;
  logic [4:0]  rs2_f;
  logic [20:0] imm_i;
  logic        hit;
  op_e         op_d;
  fmt_e        fmt_d;
  logic [4:0]  rd_d;
  logic [4:0]  rs1_d;
  logic [4:0]  rs2_d;
  logic [20:0] imm_d;
  logic        valid_q;
  s2_t         pay_q;

  assign w     = s1_i.word;
  assign f3    = w[14:12];
  assign f7    = w[31:25];
  assign rd_f  = w[11:7];
  assign rs1_f = w[19:15];
  assign rs2_f = w[24:20];
  assign imm_i = {{9{w[31]}}, w[31:20]};

  // Decode operation, format, registers and immediate
  always_comb begin
    hit   = 1'b0;
    op_d  = OP_ADD;
    fmt_d = FMT_R;
    rd_d  = '0;
    rs1_d = '0;
    rs2_d = '0;
    imm_d = '0;
    case (s1_i.cls)
      CLS_OP: begin
        rd_d = rd_f; rs1_d = rs1_f; rs2_d = rs2_f;
        if (f7 == FUNCT7_BASE) begin
          hit = 1'b1;
          case (f3)
            3'd0: op_d = OP_ADD;
            3'd1: op_d = OP_SLL;
            3'd2: op_d = OP_SLT;
            3'd3: op_d = OP_SLTU;
            3'd4: op_d = OP_XOR;
            3'd5: op_d = OP_SRL;
            3'd6: op_d = OP_OR;
            default: op_d = OP_AND;
          endcase
        end else if (f7 == FUNCT7_ALT && f3 == 3'd0) begin
          hit = 1'b1; op_d = OP_SUB;
        end else if (f7 == FUNCT7_ALT && f3 == 3'd5) begin
          hit = 1'b1; op_d = OP_SRA;
        end
      end
      CLS_OP32: begin
        rd_d = rd_f; rs1_d = rs1_f; rs2_d = rs2_f;
        if (f7 == FUNCT7_BASE) begin
          case (f3)
            3'd0: begin hit = 1'b1; op_d = OP_ADDW; end
            3'd1: begin hit = 1'b1; op_d = OP_SLLW; end
            3'd5: begin hit = 1'b1; op_d = OP_SRLW; end
            default: hit = 1'b0;
          endcase
        end else if (f7 == FUNCT7_ALT) begin
          case (f3)
            3'd0: begin hit = 1'b1; op_d = OP_SUBW; end
            3'd5: begin hit = 1'b1; op_d = OP_SRAW; end
            default: hit = 1'b0;
          endcase
        end
      end
      CLS_OPIMM: begin
        fmt_d = FMT_I; rd_d = rd_f; rs1_d = rs1_f; imm_d = imm_i;
        if (f3 inside {3'd1, 3'd5}) begin
          // RV64 shifts carry a 6-bit shift amount
          imm_d = {15'd0, w[25:20]};
          if (w[31:26] == 6'd0) begin
            hit = 1'b1; op_d = (f3 == 3'd1) ? OP_SLLI : OP_SRLI;
          end else if (w[31:26] == SHIFT_HI_ALT && f3 == 3'd5) begin
            hit = 1'b1; op_d = OP_SRAI;
          end
        end else begin
          hit = 1'b1;
          case (f3)
            3'd0: op_d = OP_ADDI;
            3'd2: op_d = OP_SLTI;
            3'd3: op_d = OP_SLTIU;
            3'd4: op_d = OP_XORI;
            3'd6: op_d = OP_ORI;
            default: op_d = OP_ANDI;
          endcase
        end
      end
      CLS_LOAD: begin
        fmt_d = FMT_I; rd_d = rd_f; rs1_d = rs1_f; imm_d = imm_i;
        hit = 1'b1;
        case (f3)
          3'd0: op_d = OP_LB;
          3'd1: op_d = OP_LH;
          3'd2: op_d = OP_LW;
          3'd3: op_d = OP_LD;
          3'd4: op_d = OP_LBU;
          3'd5: op_d = OP_LHU;
          3'd6: op_d = OP_LWU;
          default: hit = 1'b0;
        endcase
      end
      CLS_SYSTEM: begin
        fmt_d = FMT_I; rd_d = rd_f; rs1_d = rs1_f; imm_d = imm_i;
        if (f3 == 3'd0 && rd_f == 5'd0 && rs1_f == 5'd0) begin
          if (w[31:20] == 12'd0) begin
            hit = 1'b1; op_d = OP_ECALL;
          end else if (w[31:20] == 12'd1) begin
            hit = 1'b1; op_d = OP_EBREAK;
          end
        end
      end
      CLS_JALR: begin
        fmt_d = FMT_I; rd_d = rd_f; rs1_d = rs1_f; imm_d = imm_i;
        hit = (f3 == 3'd0); op_d = OP_JALR;
      end
      CLS_OPIMM32: begin
        fmt_d = FMT_I; rd_d = rd_f; rs1_d = rs1_f; imm_d = imm_i;
        if (f3 == 3'd0) begin
          hit = 1'b1; op_d = OP_ADDIW;
        end else if (f3 inside {3'd1, 3'd5}) begin
          // W shifts carry a 5-bit shift amount
          imm_d = {16'd0, w[24:20]};
          if (f7 == FUNCT7_BASE) begin
            hit = 1'b1; op_d = (f3 == 3'd1) ? OP_SLLIW : OP_SRLIW;
          end else if (f7 == FUNCT7_ALT && f3 == 3'd5) begin
            hit = 1'b1; op_d = OP_SRAIW;
          end
        end
      end
      CLS_STORE: begin
        fmt_d = FMT_S; rs1_d = rs1_f; rs2_d = rs2_f;
        imm_d = {{9{w[31]}}, w[31:25], w[11:7]};
        hit = 1'b1;
        case (f3)
          3'd0: op_d = OP_SB;
          3'd1: op_d = OP_SH;
          3'd2: op_d = OP_SW;
          3'd3: op_d = OP_SD;
          default: hit = 1'b0;
        endcase
      end
      CLS_BRANCH: begin
        fmt_d = FMT_B; rs1_d = rs1_f; rs2_d = rs2_f;
        imm_d = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        hit = 1'b1;
        case (f3)
          3'd0: op_d = OP_BEQ;
          3'd1: op_d = OP_BNE;
          3'd4: op_d = OP_BLT;
          3'd5: op_d = OP_BGE;
          3'd6: op_d = OP_BLTU;
          3'd7: op_d = OP_BGEU;
          default: hit = 1'b0;
        endcase
      end
      CLS_LUI, CLS_AUIPC: begin
        fmt_d = FMT_U; rd_d = rd_f;
        imm_d = {w[31], w[31:12]};
        hit = 1'b1;
        op_d = (s1_i.cls == CLS_LUI) ? OP_LUI : OP_AUIPC;
      end
      CLS_JAL: begin
        fmt_d = FMT_J; rd_d = rd_f;
        imm_d = {w[31], w[19:12], w[20], w[30:21], 1'b0};
        hit = 1'b1; op_d = OP_JAL;
      end
      default: hit = 1'b0;
    endcase
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s1_i.valid;
    end
  end

  // Hold decoded payload
  always_ff @(posedge clk_i) begin
    if (s1_i.valid) begin
      pay_q <= '{valid: 1'b1, bad: !hit, fmt: fmt_d, op: op_d, rd: rd_d,
                 rs1: rs1_d, rs2: rs2_d, imm: imm_d};
    end
  end

  always_comb begin
    s2_o       = pay_q;
    s2_o.valid = valid_q;
  end

endmodule

### hdl/rvd_out_stage.sv
// Last pipeline stage: clears every field of an invalid encoding and drives
// the result registers and their strobe. Depends on rvd_pkg.
module rvd_out_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rvd_pkg::s2_t s2_i,
  output logic         done_o,
  output logic         invalid_o,
  output logic [2:0]   format_o,
  output logic [5:0]   operation_o,
  output logic [4:0]   dest_reg_o,
  output logic [4:0]   src1_reg_o,
  output logic [4:0]   src2_reg_o,
  output logic [20:0]  immediate_o
);
  import rvd_pkg::*;

  logic        done_q;
  logic        invalid_q;
  logic [2:0]  format_q;
  logic [5:0]  operation_q;
  logic [4:0]  rd_q;
  logic [4:0]  rs1_q;
  logic [4:0]  rs2_q;
  logic [20:0] imm_q;

  // Advance the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_i.valid;
    end
  end

  // Drop all fields of an unknown encoding to zero
  always_ff @(posedge clk_i) begin
    if (s2_i.valid) begin
      invalid_q   <= s2_i.bad;
      format_q    <= s2_i.bad ? 3'd0 : s2_i.fmt;
      operation_q <= s2_i.bad ? 6'd0 : s2_i.op;
      rd_q        <= s2_i.bad ? 5'd0 : s2_i.rd;
      rs1_q       <= s2_i.bad ? 5'd0 : s2_i.rs1;
      rs2_q       <= s2_i.bad ? 5'd0 : s2_i.rs2;
      imm_q       <= s2_i.bad ? 21'd0 : s2_i.imm;
    end
  end

  assign done_o      = done_q;
  assign invalid_o   = invalid_q;
  assign format_o    = format_q;
  assign operation_o = operation_q;
  assign dest_reg_o  = rd_q;
  assign src1_reg_o  = rs1_q;
  assign src2_reg_o  = rs2_q;
  assign immediate_o = imm_q;

endmodule

### hdl/rvd_checker.sv
// Port-level checks for the RV64I instruction decoder and the bind that
// attaches them to the top level. Depends on rvd_pkg.
module rvd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic               invalid_o,
  input logic [2:0]         format_o,
  input logic [5:0]         operation_o,
  input logic [4:0]         dest_reg_o,
  input logic [4:0]         src1_reg_o,
  input logic [4:0]         src2_reg_o,
  input logic signed [20:0] immediate_o
);
  import rvd_pkg::*;

  // Every accepted beat yields a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("accepted beat did not produce a result");

  // No result appears without an accepted beat
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##3 !done_o)
    else $error("result without an accepted beat");

  // An invalid encoding reports all fields as zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && invalid_o) |-> (format_o == 3'd0 && operation_o == 6'd0 &&
      dest_reg_o == 5'd0 && src1_reg_o == 5'd0 && src2_reg_o == 5'd0 &&
      immediate_o == 21'sd0))
    else $error("invalid result carries nonzero fields");

  // Upper-immediate and jump formats carry no source registers
  a_uj_no_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !invalid_o && (format_o == FMT_U || format_o == FMT_J)) |->
      (src1_reg_o == 5'd0 && src2_reg_o == 5'd0))
    else $error("U or J result carries a source register");

endmodule

bind rv64i_instruction_decoder rvd_checker u_rvd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .invalid_o    (invalid_o),
  .format_o     (format_o),
  .operation_o  (operation_o),
  .dest_reg_o   (dest_reg_o),
  .src1_reg_o   (src1_reg_o),
  .src2_reg_o   (src2_reg_o),
  .immediate_o  (immediate_o)
);
